[rtl/core/zrle_pkg.sv]
// ----------------------------------------------------------------------------
// zrle_pkg
// Shared constants and types for the zero run-length encoder.
// ----------------------------------------------------------------------------
package zrle_pkg;

    // Sample width that is actually coded; upper input bits are ignored.
    localparam int SAMPLE_BITS = 16;
    localparam int IN_BITS     = 16;
    localparam int SYM_BITS    = 16;

    // Longest zero run that one count word may carry.
    localparam logic [SAMPLE_BITS-1:0] RUN_MAX = {SAMPLE_BITS{1'b1}};

    // Most coded words that one sample can cause.
    localparam int BURST_MAX = 3;

    typedef logic [SAMPLE_BITS-1:0] word_t;

    // The coded words of one item, handed from the encoder to the burst buffer.
    typedef struct packed {
        logic [1:0]                count;
        logic                      frame;
        logic [BURST_MAX-1:0][SAMPLE_BITS-1:0] word;
    } burst_t;

endpackage

[rtl/core/zrle_encode.sv]
// ----------------------------------------------------------------------------
// zrle_encode
// Turns one sample into its coded words and keeps the open zero run count.
// ----------------------------------------------------------------------------
module zrle_encode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [zrle_pkg::IN_BITS-1:0] sample,
    input  logic                         frame_last,
    input  logic                         accept,
    output zrle_pkg::burst_t             burst
);
    import zrle_pkg::*;

    word_t count_reg;
    word_t count_next;
    word_t value;
    word_t count_a;
    word_t count_b;
    logic  flush_full;
    logic  flush_end;

    always_comb
    begin
        value      = sample[SAMPLE_BITS-1:0];
        burst      = '0;
        burst.frame = frame_last;

        // A pending run closes when it is full or a literal breaks it.
        flush_full = (count_reg != '0) && ((count_reg == RUN_MAX) || (value != '0));
        count_a    = flush_full ? '0 : count_reg;
        if (flush_full)
        begin
            burst.word[0] = count_reg;
            burst.count   = 2'd1;
        end

        if (value == '0)
        begin
            if (count_a == '0)
            begin
                burst.word[burst.count] = '0;
                burst.count             = burst.count + 2'd1;
            end
            count_b = count_a + word_t'(1);
        end
        else
        begin
            burst.word[burst.count] = value;
            burst.count             = burst.count + 2'd1;
            count_b                 = count_a;
        end

        // The end of a frame flushes whatever run is still open.
        flush_end = frame_last && (count_b != '0);
        if (flush_end)
        begin
            burst.word[burst.count] = count_b;
            burst.count             = burst.count + 2'd1;
        end
        count_next = flush_end ? '0 : count_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/core/zrle_burst.sv]
// ----------------------------------------------------------------------------
// zrle_burst
// Holds the coded words of one item and feeds them one per cycle, while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module zrle_burst (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  zrle_pkg::burst_t              burst,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [zrle_pkg::SYM_BITS-1:0] symbol,
    output logic                          run_last,
    output logic                          frame_end
);
    import zrle_pkg::*;

    logic [1:0]                            cnt_reg;
    logic [1:0]                            cnt_next;
    logic                                  frame_reg;
    logic                                  frame_next;
    logic [BURST_MAX-1:0][SAMPLE_BITS-1:0] word_reg;
    logic [BURST_MAX-1:0][SAMPLE_BITS-1:0] word_next;
    logic                                  valid_reg;
    logic [SYM_BITS-1:0]                   symbol_reg;
    logic                                  run_last_reg;
    logic                                  frame_end_reg;
    logic                                  out_load;
    logic                                  pop;
    logic                                  load;

    assign out_load = !valid_reg || !out_stall;
    assign pop      = (cnt_reg != 2'd0) && out_load;
    assign free     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_load);
    assign load     = accept && (burst.count != 2'd0);

    always_comb
    begin
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        frame_next = frame_reg;
        if (load)
        begin
            cnt_next   = burst.count;
            word_next  = burst.word;
            frame_next = burst.frame;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - 2'd1;
            word_next = {word_reg[BURST_MAX-1], word_reg[BURST_MAX-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (out_load)
            begin
                valid_reg <= (cnt_reg != 2'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        frame_reg <= frame_next;
        if (out_load)
        begin
            symbol_reg    <= SYM_BITS'(word_reg[0]);
            run_last_reg  <= (cnt_reg == 2'd1);
            frame_end_reg <= (cnt_reg == 2'd1) && frame_reg;
        end
    end

    assign out_valid = valid_reg;
    assign symbol    = symbol_reg;
    assign run_last  = run_last_reg;
    assign frame_end = frame_end_reg;

endmodule

[rtl/core/zero_run_length_encoder.sv]
// ----------------------------------------------------------------------------
// zero_run_length_encoder
// Latency: a sample's first coded word reaches the output through the burst
// buffer and then the output register; the words of a burst leave in order.
// Throughput: one sample per cycle while each sample causes at most one word
// and the output is not stalled; a sample causing more words holds the input.
// Reset: asynchronous, active low; clears the open run and empties the output.
// ----------------------------------------------------------------------------
module zero_run_length_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [zrle_pkg::IN_BITS-1:0]  sample,
    input  logic                          frame_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [zrle_pkg::SYM_BITS-1:0] symbol,
    output logic                          run_last,
    output logic                          frame_end
);
    import zrle_pkg::*;

    // The encoder works out all coded words of a sample in one pass and keeps
    // the length of the zero run that is still open. The burst buffer holds
    // those words and moves them one per cycle into the output register, so
    // the only waits come from samples that cause more than one word and from
    // downstream stalls.

    burst_t burst;
    logic   free;
    logic   accept;

    // A new sample is taken once the buffer is empty or is giving up its
    // final word in this same cycle.
    assign in_stall = !free;
    assign accept   = in_valid && free;

    zrle_encode u_encode (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .frame_last (frame_last),
        .accept     (accept),
        .burst      (burst)
    );

    zrle_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .burst     (burst),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .run_last  (run_last),
        .frame_end (frame_end)
    );

`ifndef SYNTHESIS
    // The frame end word is always the last word of its sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> run_last)
        else $error("frame_end without run_last");

    // A sample that ends a frame always yields at least one word.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_last |-> burst.count != 2'd0)
        else $error("frame end sample produced no word");

    // A sample taken with an idle output shows a word, through the burst buffer
    // and the output register, whenever it causes one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (burst.count != 2'd0) && !out_valid |-> ##2 out_valid)
        else $error("coded word did not reach the output");
`endif

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zero run-length encoder. Samples go in through
// the valid/stall input channel, and a local prediction of the coding is kept.
// Each coded word that leaves is compared with the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import zrle_pkg::*;

    // The longest correct run is dominated by the two full-length zero runs
    // (about 131k samples at one per cycle). The random phases add far less.
    // The limit leaves a wide margin over both.
    localparam int CYCLE_LIMIT  = 600_000;
    // The first word leaves through the burst buffer and the output register,
    // and a burst may hold three words. These extra cycles at the end let any
    // stray word show up.
    localparam int DRAIN_CYCLES = 8;
    // There are four random phases, about 470 random samples in total.
    localparam int PHASE_ITEMS  = 118;

    // One coded word as it appears on the output channel.
    typedef struct packed {
        logic [SYM_BITS-1:0] symbol;
        logic                run_last;
        logic                frame_end;
    } coded_word_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic [IN_BITS-1:0]  sample     = '0;
    logic                frame_last = 1'b0;
    logic                out_stall  = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [SYM_BITS-1:0] symbol;
    logic                run_last;
    logic                frame_end;

    // This is the local copy of the encoder state: the length of the open run.
    logic [SYM_BITS-1:0] run_length = '0;
    // These are the words predicted so far and not yet seen on the output.
    coded_word_t         expected_words[$];

    // These knobs set the idle rate of the sender and the stall rate of the
    // receiver, in percent. Each test sets them.
    int sender_idle_pct = 0;
    int stall_pct       = 0;

    int cycle_count   = 0;
    int items_sent    = 0;
    int frames_sent   = 0;
    int words_checked = 0;
    int mismatches    = 0;

    zero_run_length_encoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .frame_last (frame_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .symbol     (symbol),
        .run_last   (run_last),
        .frame_end  (frame_end)
    );

    // The clock has a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // The receiver decides again at every falling edge whether to stall the
    // next rising edge. This spreads stalls over every position in a burst.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // The watchdog ends the run once the cycle count reaches CYCLE_LIMIT.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t ns: no progress after %0d cycles, %0d words still expected",
                     $time, cycle_count, expected_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic coded_word_t word_of(input logic [SYM_BITS-1:0] value);
        coded_word_t w;
        w.symbol    = value;
        w.run_last  = 1'b0;
        w.frame_end = 1'b0;
        return w;
    endfunction

    // This task works out the coded words for one accepted sample. First, an
    // open run is closed if it is full or if the sample is nonzero. Next, the
    // sample itself is coded: a zero opens or extends a run, and any other
    // value is passed through as a literal. Last, a frame end flushes any run
    // that is still open.
    task automatic code_sample(input logic [IN_BITS-1:0] raw, input logic last);
        word_t       value;
        coded_word_t burst[$];
        // Only the low SAMPLE_BITS bits of the bus count.
        value = word_t'(raw);
        if (run_length != 0 && (run_length >= RUN_MAX || value != 0))
        begin
            burst      = {burst, word_of(run_length)};
            run_length = '0;
        end
        if (value == 0)
        begin
            if (run_length == 0)
                burst = {burst, word_of('0)};
            run_length = run_length + 1'b1;
        end
        else
        begin
            burst = {burst, word_of(SYM_BITS'(value))};
        end
        if (last && run_length != 0)
        begin
            burst      = {burst, word_of(run_length)};
            run_length = '0;
        end
        // A zero that extends an open run without ending the frame gives no word.
        if (burst.size() != 0)
        begin
            burst[burst.size()-1].run_last  = 1'b1;
            burst[burst.size()-1].frame_end = last;
        end
        expected_words = {expected_words, burst};
    endtask

    // This task sends one sample. The payload is driven at a falling edge,
    // after an optional random idle stretch. It is held until a rising edge
    // finds valid high and stall low. The prediction is made at that edge.
    task automatic send_sample(input logic [IN_BITS-1:0] value, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        sample     <= value;
        frame_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        code_sample(value, last);
        items_sent++;
        if (last)
            frames_sent++;
    endtask

    function automatic void report_field(input string field,
                                         input logic [SYM_BITS-1:0] want,
                                         input logic [SYM_BITS-1:0] got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    // The checker sees each word that the receiver accepts. It compares that
    // word with the oldest prediction, one field at a time. A word that
    // arrives when nothing is expected is also a failure.
    always @(posedge clk)
    begin : check_words
        coded_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                $display({"%0t ns: unexpected word, expected none, ",
                          "actual symbol %h run_last %b frame_end %b"},
                         $time, symbol, run_last, frame_end);
            end
            else
            begin
                want = expected_words.pop_front();
                if (symbol !== want.symbol)
                    report_field("symbol", want.symbol, symbol);
                if (run_last !== want.run_last)
                    report_field("run_last", SYM_BITS'(want.run_last), SYM_BITS'(run_last));
                if (frame_end !== want.frame_end)
                    report_field("frame_end", SYM_BITS'(want.frame_end), SYM_BITS'(frame_end));
                words_checked++;
            end
        end
    end

    // These are nonzero samples, mostly at the extremes of the field. Some of them end
    // frames, so a literal can be the final word of a frame.
    task automatic test_literals();
        sender_idle_pct = 0;
        stall_pct       = 0;
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h00FF, 1'b0);
        send_sample(16'h5AA5, 1'b1);
        send_sample(16'hA55A, 1'b0);
    endtask

    // These are short zero runs. A run can be closed by a literal or flushed by
    // a frame end. A single zero can end a frame, which gives a marker and a
    // count of one. A zero inside an open run gives no word. Some stall and
    // idle is applied so that bursts of two words meet backpressure.
    task automatic test_zero_runs();
        sender_idle_pct = 28;
        stall_pct       = 28;
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h1234, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h00FF, 1'b0);
    endtask

    // These runs reach the full count. The first full run is split by one more
    // zero, which gives the full count and a new marker. The second full run
    // is split by a zero that also ends the frame, which gives three words:
    // the full count, a marker, and a flushed count of one.
    task automatic test_full_runs();
        sender_idle_pct = 0;
        stall_pct       = 0;
        repeat (int'(RUN_MAX))
            send_sample('0, 1'b0);
        send_sample('0, 1'b0);
        repeat (int'(RUN_MAX) - 1)
            send_sample('0, 1'b0);
        send_sample('0, 1'b1);
    endtask

    // This is random traffic made of zero runs (mostly short, some longer) and
    // literals. The literals lean toward the extremes and single set bits.
    // Frame ends fall on about one sample in twelve.
    task automatic test_random_phase(input int idle_pct, input int stall_in_pct);
        int                 sent;
        int                 run;
        logic [IN_BITS-1:0] value;
        sender_idle_pct = idle_pct;
        stall_pct       = stall_in_pct;
        sent            = 0;
        while (sent < PHASE_ITEMS)
        begin
            if ($urandom_range(9) < 4)
            begin
                run = ($urandom_range(7) == 0) ? $urandom_range(80, 20)
                                               : $urandom_range(6, 1);
                repeat (run)
                begin
                    send_sample('0, $urandom_range(11) == 0);
                    sent++;
                end
            end
            else
            begin
                case ($urandom_range(5))
                    0:       value = 16'hFFFF;
                    1:       value = 16'h0001;
                    2:       value = 16'h00FF;
                    3:       value = 16'h0001 << $urandom_range(15);
                    default: value = IN_BITS'($urandom_range(16'hFFFF, 1));
                endcase
                send_sample(value, $urandom_range(11) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        // Reset is held low at the start and then released at a falling edge.
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_literals();
        test_zero_runs();
        test_full_runs();
        test_random_phase(0, 0);
        test_random_phase(46, 0);
        test_random_phase(0, 46);
        test_random_phase(28, 28);

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Coded %0d samples in %0d frames and checked %0d words with %0d mismatches.",
                 items_sent, frames_sent, words_checked, mismatches);
        $display("Covered: literals, short runs, frame flushes, two full runs, four traffic mixes.");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
